/* design/binary_to_decimal_digits_defines.svh */
// Assertion macros used by the top-level design file.
`ifndef BINARY_TO_DECIMAL_DIGITS_DEFINES_SVH
`define BINARY_TO_DECIMAL_DIGITS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define B2D_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define B2D_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/b2d_pkg.sv */
package b2d_pkg;

    localparam int VALUE_W    = 64;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int COL_W      = 5;
    localparam int CHAR_W     = 6;
    localparam int BIT_CNT_W  = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;

    // One converted number: packed BCD, digit 0 in the low nibble, and its digit count.
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [COL_W-1:0] count;
    } conv_entry_t;

endpackage

/* design/b2d_front.sv */
module b2d_front
    import b2d_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    output logic               push_valid,
    input  logic               push_ready,
    output conv_entry_t        push_entry
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_PUSH = 3'b100
    } front_state_t;

    front_state_t           state_reg, state_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [COL_W-1:0]       count_reg, count_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;

    logic [BCD_W-1:0]       bcd_adj;
    logic [BCD_W-1:0]       bcd_shift;
    logic [COL_W-1:0]       probe_idx;
    logic [DIGIT_W-1:0]     probe_digit;

    // Shift-add-3: fix up every nibble that would overflow on doubling.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign bcd_shift = {bcd_adj[BCD_W-2:0], value_reg[VALUE_W-1]};

    // Digit count grows by at most one per step; watch the nibble just above it.
    assign probe_idx   = (count_reg < COL_W'(NUM_DIGITS)) ? count_reg : '0;
    assign probe_digit = bcd_shift[probe_idx*DIGIT_W +: DIGIT_W];

    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        bcd_next     = bcd_reg;
        count_next   = count_reg;
        bit_cnt_next = bit_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    value_next   = s_value;
                    bcd_next     = '0;
                    count_next   = COL_W'(1);
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next     = bcd_shift;
                value_next   = {value_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (count_reg < COL_W'(NUM_DIGITS) && probe_digit != '0) begin
                    count_next = count_reg + COL_W'(1);
                end
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1)) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        value_reg   <= value_next;
        bcd_reg     <= bcd_next;
        count_reg   <= count_next;
        bit_cnt_reg <= bit_cnt_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign push_valid       = (state_reg == ST_PUSH);
    assign push_entry.bcd   = bcd_reg;
    assign push_entry.count = count_reg;

endmodule

/* design/b2d_queue.sv */
module b2d_queue
    import b2d_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  conv_entry_t push_entry,
    output logic        pop_valid,
    input  logic        pop_ready,
    output conv_entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    conv_entry_t        mem [DEPTH];
    conv_entry_t        head_reg;
    logic               head_valid_reg, head_valid_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               do_push, do_pop;
    logic               head_free, mem_wr, mem_rd, bypass;

    // Head of the queue lives in its own register; the array holds the entries behind it.
    // An empty queue passes a push straight into the head.
    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = head_valid_reg;
    assign pop_entry  = head_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = head_valid_reg && pop_ready;
    assign head_free  = !head_valid_reg || do_pop;
    assign mem_rd     = head_free && (fill_reg != '0);
    assign bypass     = do_push && head_free && (fill_reg == '0);
    assign mem_wr     = do_push && !bypass;

    always_comb begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        fill_next       = fill_reg;
        head_valid_next = head_valid_reg;
        if (mem_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (mem_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (mem_wr && !mem_rd) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (mem_rd && !mem_wr) begin
            fill_next = fill_reg - CNT_W'(1);
        end
        if (head_free) begin
            head_valid_next = mem_rd || bypass;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
            head_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fill_reg       <= fill_next;
            head_valid_reg <= head_valid_next;
        end
        if (mem_wr) begin
            mem[wr_ptr_reg] <= push_entry;
        end
        if (mem_rd) begin
            head_reg <= mem[rd_ptr_reg];
        end else if (bypass) begin
            head_reg <= push_entry;
        end
    end

endmodule

/* design/b2d_back.sv */
module b2d_back
    import b2d_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  conv_entry_t       pop_entry,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_code,
    output logic [COL_W-1:0]  m_column,
    output logic              m_last
);

    logic               busy_reg, busy_next;
    logic [BCD_W-1:0]   digits_reg, digits_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               out_done;

    assign out_done  = busy_reg && m_ready;
    // Load the next number once the most significant digit of this one goes out.
    assign pop_ready = !busy_reg || (out_done && col_reg == '0);

    always_comb begin
        busy_next   = busy_reg;
        digits_next = digits_reg;
        col_next    = col_reg;
        if (pop_valid && pop_ready) begin
            busy_next   = 1'b1;
            digits_next = pop_entry.bcd;
            col_next    = pop_entry.count - COL_W'(1);
        end else if (out_done) begin
            digits_next = {DIGIT_W'(0), digits_reg[BCD_W-1:DIGIT_W]};
            col_next    = col_reg - COL_W'(1);
            if (col_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        digits_reg <= digits_next;
        col_reg    <= col_next;
    end

    assign m_valid     = busy_reg;
    assign m_char_code = CHAR_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, digits_reg[DIGIT_W-1:0]};
    assign m_column    = col_reg;
    assign m_last      = (col_reg == '0);

endmodule

/* design/binary_to_decimal_digits.sv */
// Throughput: the front end takes a new number only after its 64-step shift-add-3
//   loop has finished and the result has gone into the queue; digit output runs at
//   one transaction a cycle while m_ready is high.
// A number of n digits takes n output transactions; a slow sink is absorbed by the queue.
// Reset: synchronous, active-low aresetn empties the queue and idles both ends.
`include "binary_to_decimal_digits_defines.svh"

module binary_to_decimal_digits
    import b2d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAR_W-1:0]  m_char_code,
    output logic [COL_W-1:0]   m_column,
    output logic               m_last
);

    // Front end: takes one value and runs double-dabble over its 64 bits, one bit a
    // cycle, tracking the digit count as the BCD word grows.
    logic        push_valid, push_ready;
    conv_entry_t push_entry;

    // Back end: emits digits least significant first; column counts down to 0 on the
    // most significant digit, which closes the number.
    logic        pop_valid, pop_ready;
    conv_entry_t pop_entry;

    b2d_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Short queue of finished conversions so the front can start the next number
    // while the back is still streaming digits.
    b2d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    b2d_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_entry   (pop_entry),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_column    (m_column),
        .m_last      (m_last)
    );

    // Every digit leaving must be a decimal character.
    `B2D_ASSERT_SAME(a_char_decimal, aclk, aresetn, m_valid, (m_char_code >= CHAR_ZERO) && (m_char_code <= CHAR_ZERO + 6'd9), "digit outside '0'..'9'")
    // Within a number the digits follow one another with the column stepping down.
    `B2D_ASSERT_NEXT(a_col_step, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && (m_column == COL_W'($past(m_column) - COL_W'(1))), "digit string broken")
    // The front end is busy converting for the cycle after it takes a value.
    `B2D_ASSERT_NEXT(a_front_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "front end took two values back to back")

endmodule
